FILE: hw/rtl/segx_pkg.sv
package segx_pkg;

    // default geometry of the datapath
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // fixed width of each result coordinate
    localparam int CROSS_BITS = 24;

    // result flag positions in tuser
    localparam int USER_HIT      = 0;
    localparam int USER_PARALLEL = 1;
    localparam int USER_BITS     = 2;

endpackage

FILE: hw/rtl/segment_intersection_core.sv
// segment pair intersection, fully pipelined
//
// s_* channel: one item per pair of segments, eight signed coordinates of
// COORD_BITS each in s_tdata (first start x in the lowest bits).
// m_* channel: one item per input item, in order. m_tdata holds cross_x
// and cross_y (24-bit two's complement, FRAC_BITS fraction bits), m_tuser
// holds the hit and parallel flags. a miss or a parallel pair gives zero
// coordinates.
// throughput: one item per cycle while the receiver takes results; the
// quotient is formed one bit per stage by two restoring dividers of
// 3*COORD_BITS+4+FRAC_BITS stages each.
// reset clears all valid bits; the pipeline is empty and s_tready is high.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
module segment_intersection_core #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segx_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [8*COORD_BITS-1:0]             s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cross_x, cross_y
    output logic [2*segx_pkg::CROSS_BITS-1:0]   m_tdata,
    // hit, parallel
    output logic [segx_pkg::USER_BITS-1:0]      m_tuser
);
    import segx_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int DW    = W + 1;
    localparam int PW    = 2 * W + 1;
    localparam int CW    = 2 * W + 2;
    localparam int DETW  = 2 * W + 3;
    localparam int XW    = CW + DW;
    localparam int NUMW  = 3 * W + 4;
    localparam int NB    = NUMW + F;
    localparam int VW    = W + F + 1;
    localparam int EXTW  = (VW > CROSS_BITS) ? VW : CROSS_BITS;
    localparam int BOXW  = 8 * W;

    logic en;

    // whole pipeline moves unless a result waits on a stalled receiver
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input unpack
    logic signed [W-1:0] p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
    assign p0x = s_tdata[0*W +: W];
    assign p0y = s_tdata[1*W +: W];
    assign p1x = s_tdata[2*W +: W];
    assign p1y = s_tdata[3*W +: W];
    assign q0x = s_tdata[4*W +: W];
    assign q0y = s_tdata[5*W +: W];
    assign q1x = s_tdata[6*W +: W];
    assign q1y = s_tdata[7*W +: W];

    // stage 1: line coefficients and bounding boxes
    logic                 v1_reg;
    logic signed [DW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [W-1:0]  p0x_reg, p0y_reg, q0x_reg, q0y_reg;
    logic [BOXW-1:0]      box1_reg, box1_next;

    always_comb
    begin
        box1_next[0*W +: W] = ($signed(p0x) < $signed(p1x)) ? p0x : p1x;
        box1_next[1*W +: W] = ($signed(p0x) < $signed(p1x)) ? p1x : p0x;
        box1_next[2*W +: W] = ($signed(p0y) < $signed(p1y)) ? p0y : p1y;
        box1_next[3*W +: W] = ($signed(p0y) < $signed(p1y)) ? p1y : p0y;
        box1_next[4*W +: W] = ($signed(q0x) < $signed(q1x)) ? q0x : q1x;
        box1_next[5*W +: W] = ($signed(q0x) < $signed(q1x)) ? q1x : q0x;
        box1_next[6*W +: W] = ($signed(q0y) < $signed(q1y)) ? q0y : q1y;
        box1_next[7*W +: W] = ($signed(q0y) < $signed(q1y)) ? q1y : q0y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= DW'(p1y) - DW'(p0y);
            b1_reg   <= DW'(p0x) - DW'(p1x);
            a2_reg   <= DW'(q1y) - DW'(q0y);
            b2_reg   <= DW'(q0x) - DW'(q1x);
            p0x_reg  <= p0x;
            p0y_reg  <= p0y;
            q0x_reg  <= q0x;
            q0y_reg  <= q0y;
            box1_reg <= box1_next;
        end
    end

    // stage 2: products for c and det
    logic                    v2_reg;
    logic signed [PW-1:0]    m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [CW-1:0]    d1_reg, d2_reg;
    logic signed [DW-1:0]    a1s2_reg, b1s2_reg, a2s2_reg, b2s2_reg;
    logic [BOXW-1:0]         box2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= PW'(a1_reg) * PW'(p0x_reg);
            m2_reg   <= PW'(b1_reg) * PW'(p0y_reg);
            m3_reg   <= PW'(a2_reg) * PW'(q0x_reg);
            m4_reg   <= PW'(b2_reg) * PW'(q0y_reg);
            d1_reg   <= CW'(a1_reg) * CW'(b2_reg);
            d2_reg   <= CW'(b1_reg) * CW'(a2_reg);
            a1s2_reg <= a1_reg;
            b1s2_reg <= b1_reg;
            a2s2_reg <= a2_reg;
            b2s2_reg <= b2_reg;
            box2_reg <= box1_reg;
        end
    end

    // stage 3: c terms and determinant
    logic                    v3_reg;
    logic signed [CW-1:0]    c1_reg, c2_reg;
    logic signed [DETW-1:0]  det3_reg;
    logic signed [DW-1:0]    a1s3_reg, b1s3_reg, a2s3_reg, b2s3_reg;
    logic [BOXW-1:0]         box3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= CW'(m1_reg) + CW'(m2_reg);
            c2_reg   <= CW'(m3_reg) + CW'(m4_reg);
            det3_reg <= DETW'(d1_reg) - DETW'(d2_reg);
            a1s3_reg <= a1s2_reg;
            b1s3_reg <= b1s2_reg;
            a2s3_reg <= a2s2_reg;
            b2s3_reg <= b2s2_reg;
            box3_reg <= box2_reg;
        end
    end

    // stage 4: numerator products
    logic                    v4_reg;
    logic signed [XW-1:0]    nx1_reg, nx2_reg, ny1_reg, ny2_reg;
    logic signed [DETW-1:0]  det4_reg;
    logic [BOXW-1:0]         box4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx1_reg  <= XW'(c1_reg) * XW'(b2s3_reg);
            nx2_reg  <= XW'(b1s3_reg) * XW'(c2_reg);
            ny1_reg  <= XW'(a1s3_reg) * XW'(c2_reg);
            ny2_reg  <= XW'(c1_reg) * XW'(a2s3_reg);
            det4_reg <= det3_reg;
            box4_reg <= box3_reg;
        end
    end

    // stage 5: numerators to sign and magnitude
    logic signed [NUMW-1:0] numx, numy;
    logic [NUMW-1:0]        magx, magy;
    logic [DETW-1:0]        dmag;

    assign numx = NUMW'(nx1_reg) - NUMW'(nx2_reg);
    assign numy = NUMW'(ny1_reg) - NUMW'(ny2_reg);
    assign magx = numx[NUMW-1] ? NUMW'(-numx) : NUMW'(numx);
    assign magy = numy[NUMW-1] ? NUMW'(-numy) : NUMW'(numy);
    assign dmag = det4_reg[DETW-1] ? DETW'(-det4_reg) : DETW'(det4_reg);

    // divider chain, entry 0 loaded by stage 5
    logic            dv_reg   [0:NB];
    logic            par_reg  [0:NB];
    logic            negx_reg [0:NB];
    logic            negy_reg [0:NB];
    logic [DETW-1:0] d_reg    [0:NB];
    logic [DETW-1:0] rx_reg   [0:NB];
    logic [DETW-1:0] ry_reg   [0:NB];
    logic [NB-1:0]   nx_reg   [0:NB];
    logic [NB-1:0]   ny_reg   [0:NB];
    logic [NB-1:0]   qx_reg   [0:NB];
    logic [NB-1:0]   qy_reg   [0:NB];
    logic [BOXW-1:0] boxd_reg [0:NB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg[0]  <= (det4_reg == '0);
            negx_reg[0] <= numx[NUMW-1] ^ det4_reg[DETW-1];
            negy_reg[0] <= numy[NUMW-1] ^ det4_reg[DETW-1];
            d_reg[0]    <= dmag;
            rx_reg[0]   <= '0;
            ry_reg[0]   <= '0;
            nx_reg[0]   <= NB'(magx) << F;
            ny_reg[0]   <= NB'(magy) << F;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            boxd_reg[0] <= box4_reg;
        end
    end

    // one quotient bit per stage for each coordinate
    for (genvar k = 0; k < NB; k++)
    begin : g_div
        logic [DETW:0]   shx, shy;
        logic            gex, gey;
        logic [DETW-1:0] rx_next, ry_next;

        assign shx     = {rx_reg[k], nx_reg[k][NB-1]};
        assign shy     = {ry_reg[k], ny_reg[k][NB-1]};
        assign gex     = shx >= {1'b0, d_reg[k]};
        assign gey     = shy >= {1'b0, d_reg[k]};
        assign rx_next = gex ? DETW'(shx - {1'b0, d_reg[k]}) : DETW'(shx);
        assign ry_next = gey ? DETW'(shy - {1'b0, d_reg[k]}) : DETW'(shy);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                par_reg[k+1]  <= par_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                d_reg[k+1]    <= d_reg[k];
                rx_reg[k+1]   <= rx_next;
                ry_reg[k+1]   <= ry_next;
                nx_reg[k+1]   <= nx_reg[k] << 1;
                ny_reg[k+1]   <= ny_reg[k] << 1;
                qx_reg[k+1]   <= {qx_reg[k][NB-2:0], gex};
                qy_reg[k+1]   <= {qy_reg[k][NB-2:0], gey};
                boxd_reg[k+1] <= boxd_reg[k];
            end
        end
    end

    // post stage: range check and signed quotient
    logic                 pv_reg, ppar_reg, pbigx_reg, pbigy_reg;
    logic signed [VW-1:0] pvx_reg, pvy_reg;
    logic [BOXW-1:0]      pbox_reg;
    logic [VW-1:0]        qxs, qys;

    assign qxs = {1'b0, qx_reg[NB][W+F-1:0]};
    assign qys = {1'b0, qy_reg[NB][W+F-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= dv_reg[NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ppar_reg  <= par_reg[NB];
            pbigx_reg <= |qx_reg[NB][NB-1:W+F];
            pbigy_reg <= |qy_reg[NB][NB-1:W+F];
            pvx_reg   <= negx_reg[NB] ? $signed(-qxs) : $signed(qxs);
            pvy_reg   <= negy_reg[NB] ? $signed(-qys) : $signed(qys);
            pbox_reg  <= boxd_reg[NB];
        end
    end

    // box test against both segments
    logic signed [VW-1:0]   lo_px, hi_px, lo_py, hi_py, lo_qx, hi_qx, lo_qy, hi_qy;
    logic                   hit_next;
    logic signed [EXTW-1:0] extx, exty;

    assign lo_px = VW'($signed(pbox_reg[0*W +: W])) <<< F;
    assign hi_px = VW'($signed(pbox_reg[1*W +: W])) <<< F;
    assign lo_py = VW'($signed(pbox_reg[2*W +: W])) <<< F;
    assign hi_py = VW'($signed(pbox_reg[3*W +: W])) <<< F;
    assign lo_qx = VW'($signed(pbox_reg[4*W +: W])) <<< F;
    assign hi_qx = VW'($signed(pbox_reg[5*W +: W])) <<< F;
    assign lo_qy = VW'($signed(pbox_reg[6*W +: W])) <<< F;
    assign hi_qy = VW'($signed(pbox_reg[7*W +: W])) <<< F;

    assign hit_next = !ppar_reg && !pbigx_reg && !pbigy_reg
                   && (pvx_reg >= lo_px) && (pvx_reg <= hi_px)
                   && (pvy_reg >= lo_py) && (pvy_reg <= hi_py)
                   && (pvx_reg >= lo_qx) && (pvx_reg <= hi_qx)
                   && (pvy_reg >= lo_qy) && (pvy_reg <= hi_qy);

    assign extx = EXTW'(pvx_reg);
    assign exty = EXTW'(pvy_reg);

    // output register
    logic                        out_valid_reg;
    logic [2*CROSS_BITS-1:0]     out_data_reg;
    logic [USER_BITS-1:0]        out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_user_reg[USER_HIT]      <= hit_next;
            out_user_reg[USER_PARALLEL] <= ppar_reg;
            out_data_reg <= hit_next ? {exty[CROSS_BITS-1:0], extx[CROSS_BITS-1:0]} : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // checks
    a_par_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_PARALLEL] |-> !m_tuser[USER_HIT])
        else $error("parallel result reported as hit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[USER_HIT] |-> (m_tdata == '0))
        else $error("miss with nonzero coordinates");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready disagrees with output stall");

endmodule
